@@ design/rgb_run_length_chunk_decoder_defines.svh @@
// Assertion macros for the run-length chunk decoder.
// Expects clk and arst_n in the scope of each use.
`ifndef RGB_RUN_LENGTH_CHUNK_DECODER_DEFINES_SVH
`define RGB_RUN_LENGTH_CHUNK_DECODER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RLC_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define RLC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/rlc_pkg.sv @@
// Shared types and codes for the run-length chunk decoder.
// No dependencies.
package rlc_pkg;

	localparam int MAX_RUNS_DEF = 256;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       chunk_end;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  literal_byte;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [15:0] run_length;
		logic        is_last;
		logic [1:0]  error;
	} result_t;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_TABLE,
		PH_DATA,
		PH_DESC,
		PH_DISCARD
	} phase_t;

	typedef struct packed {
		logic        en;
		logic [15:0] data;
	} tbl_wr_t;

	localparam logic [1:0] KIND_LIT = 2'd0;
	localparam logic [1:0] KIND_RUN = 2'd1;
	localparam logic [1:0] KIND_END = 2'd2;

	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_RUNS  = 2'd1;
	localparam logic [1:0] ERR_TRUNC = 2'd2;

	// header byte positions
	localparam logic [1:0] HDR_CNT_LO = 2'd2;
	localparam logic [1:0] HDR_CNT_HI = 2'd3;

	// descriptor byte positions
	localparam logic [2:0] DESC_LEN_LO = 3'd0;
	localparam logic [2:0] DESC_LEN_HI = 3'd1;
	localparam logic [2:0] DESC_RED    = 3'd2;
	localparam logic [2:0] DESC_GREEN  = 3'd3;
	localparam logic [2:0] DESC_BLUE   = 3'd4;

endpackage

@@ design/rlc_table_ram.sv @@
// Run position table: one write port, one registered read port.
// A write to the entry being read is forwarded. Depends on rlc_pkg.
module rlc_table_ram #(
	parameter int DEPTH = rlc_pkg::MAX_RUNS_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic            clk,
	input  rlc_pkg::tbl_wr_t wr,
	input  logic [AW-1:0]   waddr,
	input  logic [AW-1:0]   raddr,
	output logic [15:0]     rdata
);
	import rlc_pkg::*;

	logic [15:0] mem [DEPTH];
	logic [15:0] rdata_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[waddr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && (waddr == raddr)) begin
			rdata_q <= wr.data;
		end else begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/rlc_parser.sv @@
// Chunk parser: header, table fill, data and descriptor phases.
// Writes run positions to the table and compares against its prefetched entry.
// Depends on rlc_pkg.
module rlc_parser #(
	parameter int MAX_RUNS = rlc_pkg::MAX_RUNS_DEF,
	parameter int AW       = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  rlc_pkg::item_t   item,
	output rlc_pkg::tbl_wr_t tbl_wr,
	output logic [AW-1:0]    tbl_waddr,
	output logic [AW-1:0]    tbl_raddr,
	input  logic [15:0]      tbl_rdata,
	output logic             res_valid,
	output rlc_pkg::result_t res
);
	import rlc_pkg::*;

	localparam int RW = $clog2(MAX_RUNS + 1);
	localparam int FW = $clog2(2 * MAX_RUNS + 1);

	phase_t        phase_q, phase_d;
	logic [1:0]    hbs_q, hbs_d;
	logic [RW-1:0] run_total_q, run_total_d;
	logic [RW-1:0] runs_done_q, runs_done_d;
	logic [FW-1:0] fill_q, fill_d;
	logic [15:0]   pos_q, pos_d;
	logic [2:0]    desc_q, desc_d;
	logic [7:0]    low_q, low_d;
	logic [15:0]   len_q, len_d;
	logic [15:0]   col_q, col_d;

	logic [15:0]   cnt_word;
	logic          too_many;
	logic [FW-1:0] fill_inc;
	logic [FW-2:0] fill_idx;
	logic [FW-2:0] wr_idx;
	logic [15:0]   pos_inc;
	logic [RW-1:0] done_inc;
	logic          runs_left;
	logic          run_due;
	logic [7:0]    b;
	logic          fin;

	function automatic result_t end_marker(input logic [1:0] err);
		result_t r;
		r         = '0;
		r.kind    = KIND_END;
		r.is_last = 1'b1;
		r.error   = err;
		return r;
	endfunction

	assign b         = item.data_byte;
	assign fin       = item.chunk_end;
	assign cnt_word  = {b, low_q};
	assign too_many  = cnt_word > 16'(MAX_RUNS);
	assign fill_inc  = fill_q + 1'b1;
	assign fill_idx  = fill_inc[FW-1:1];
	assign wr_idx    = fill_q[FW-1:1];
	assign pos_inc   = (pos_q == 16'hFFFF) ? pos_q : pos_q + 16'd1;
	assign done_inc  = runs_done_q + 1'b1;
	assign runs_left = runs_done_q < run_total_q;
	// table entry for runs_done_q is already registered at the read port
	assign run_due   = runs_left && (pos_q >= tbl_rdata);

	always_comb begin
		phase_d     = phase_q;
		hbs_d       = hbs_q;
		run_total_d = run_total_q;
		runs_done_d = runs_done_q;
		fill_d      = fill_q;
		pos_d       = pos_q;
		desc_d      = desc_q;
		low_d       = low_q;
		len_d       = len_q;
		col_d       = col_q;
		tbl_wr      = '0;
		res_valid   = 1'b0;
		res         = '0;

		if (accept) begin
			case (phase_q)
				PH_HEADER: begin
					if (hbs_q == HDR_CNT_HI) begin
						hbs_d       = '0;
						run_total_d = cnt_word[RW-1:0];
						if (too_many) begin
							phase_d = PH_DISCARD;
						end else if (cnt_word == 16'd0) begin
							phase_d = PH_DATA;
							pos_d   = '0;
						end else begin
							phase_d = PH_TABLE;
							fill_d  = '0;
						end
						if (fin) begin
							res_valid = 1'b1;
							res = end_marker(too_many ? ERR_RUNS :
								((cnt_word != 16'd0) ? ERR_TRUNC : ERR_NONE));
						end
					end else begin
						if (hbs_q == HDR_CNT_LO) begin
							low_d = b;
						end
						hbs_d = hbs_q + 2'd1;
						if (fin) begin
							res_valid = 1'b1;
							res       = end_marker(ERR_TRUNC);
						end
					end
				end
				PH_TABLE: begin
					if (!fill_q[0]) begin
						low_d = b;
					end else begin
						tbl_wr.en   = wr_idx < (FW-1)'(MAX_RUNS);
						tbl_wr.data = {b, low_q};
					end
					fill_d = fill_inc;
					if (fill_idx >= run_total_q) begin
						phase_d = PH_DATA;
						pos_d   = '0;
					end
					if (fin) begin
						res_valid = 1'b1;
						res       = end_marker(ERR_TRUNC);
					end
				end
				PH_DATA: begin
					pos_d = pos_inc;
					if (run_due) begin
						// this byte is the first of a descriptor
						phase_d = PH_DESC;
						low_d   = b;
						desc_d  = DESC_LEN_HI;
						if (fin) begin
							res_valid = 1'b1;
							res       = end_marker(ERR_TRUNC);
						end
					end else begin
						res_valid        = 1'b1;
						res.kind         = KIND_LIT;
						res.literal_byte = b;
						res.is_last      = fin;
						res.error        = (fin && runs_left) ? ERR_TRUNC : ERR_NONE;
					end
				end
				PH_DESC: begin
					pos_d = pos_inc;
					if (desc_q >= DESC_BLUE) begin
						desc_d         = DESC_LEN_LO;
						runs_done_d    = done_inc;
						phase_d        = PH_DATA;
						res_valid      = 1'b1;
						res.kind       = KIND_RUN;
						res.red        = col_q[7:0];
						res.green      = col_q[15:8];
						res.blue       = b;
						res.run_length = len_q;
						res.is_last    = fin;
						res.error      = (fin && (done_inc < run_total_q)) ?
							ERR_TRUNC : ERR_NONE;
					end else begin
						case (desc_q)
							DESC_LEN_LO: low_d = b;
							DESC_LEN_HI: len_d = {b, low_q};
							DESC_RED:    col_d[7:0] = b;
							DESC_GREEN:  col_d[15:8] = b;
							default:     col_d = col_q;
						endcase
						desc_d = desc_q + 3'd1;
						if (fin) begin
							res_valid = 1'b1;
							res       = end_marker(ERR_TRUNC);
						end
					end
				end
				default: begin
					if (fin) begin
						res_valid = 1'b1;
						res       = end_marker(ERR_RUNS);
					end
				end
			endcase

			// final result of a chunk: start over for the next one
			if (res_valid && res.is_last) begin
				phase_d     = PH_HEADER;
				hbs_d       = '0;
				run_total_d = '0;
				runs_done_d = '0;
				fill_d      = '0;
				pos_d       = '0;
				desc_d      = DESC_LEN_LO;
			end
		end
	end

	assign tbl_waddr = wr_idx[AW-1:0];
	// prefetch the entry for the next cycle's runs_done
	assign tbl_raddr = runs_done_d[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			hbs_q       <= '0;
			run_total_q <= '0;
			runs_done_q <= '0;
			fill_q      <= '0;
			pos_q       <= '0;
			desc_q      <= DESC_LEN_LO;
		end else begin
			phase_q     <= phase_d;
			hbs_q       <= hbs_d;
			run_total_q <= run_total_d;
			runs_done_q <= runs_done_d;
			fill_q      <= fill_d;
			pos_q       <= pos_d;
			desc_q      <= desc_d;
		end
	end

	always_ff @(posedge clk) begin
		low_q <= low_d;
		len_q <= len_d;
		col_q <= col_d;
	end

endmodule

@@ design/rlc_out_buf.sv @@
// Output register with a one-entry skid stage.
// Upstream may transfer while a result waits downstream. Depends on rlc_pkg.
module rlc_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             res_valid,
	input  rlc_pkg::result_t res,
	output logic             take_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output rlc_pkg::result_t out_res
);
	import rlc_pkg::*;

	logic    out_v_q;
	result_t out_q;
	logic    skid_v_q;
	result_t skid_q;
	logic    out_free;

	assign out_free   = !out_v_q || out_ready;
	assign take_ready = !skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_free) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= res_valid;
			end
		end else if (res_valid) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_v_q ? skid_q : res;
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	assign out_valid = out_v_q;
	assign out_res   = out_q;

endmodule

@@ design/rgb_run_length_chunk_decoder.sv @@
// Decoder for run-length coded RGB chunks: takes one byte per transfer on the
// item channel and emits literal, run and end-marker results on the result channel.
//
// Item channel: item_valid/item_ready, payload item (data_byte, chunk_end).
// Result channel: result_valid/result_ready, payload result.
// Each accepted byte yields zero or one result, in order. A result is
// registered in the output register, or in the skid stage when the receiver
// stalls. Throughput is one byte per cycle while item_ready is high; the limit
// is the single read port of the run position table, which is prefetched
// every cycle for the next run index, with writes to the same entry forwarded.
// When the receiver stalls, one result is held in the output register and a
// second in a skid stage; item_ready then drops until the skid drains.
// Reset clears the parser to the header phase and empties both output stages.
// The run position table is not cleared; each chunk writes its entries before
// reading them. After the last byte of a chunk the parser returns to the
// header phase on its own.
// Depends on rlc_pkg, rlc_parser, rlc_table_ram, rlc_out_buf and the defines.
`include "rgb_run_length_chunk_decoder_defines.svh"

module rgb_run_length_chunk_decoder #(
	parameter int MAX_RUNS = rlc_pkg::MAX_RUNS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  rlc_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output rlc_pkg::result_t result
);
	import rlc_pkg::*;

	localparam int AW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;

	logic          accept;
	tbl_wr_t       tbl_wr;
	logic [AW-1:0] tbl_waddr;
	logic [AW-1:0] tbl_raddr;
	logic [15:0]   tbl_rdata;
	logic          res_valid;
	result_t       res;

	assign accept = item_valid && item_ready;

	rlc_parser #(
		.MAX_RUNS (MAX_RUNS),
		.AW       (AW)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.tbl_wr    (tbl_wr),
		.tbl_waddr (tbl_waddr),
		.tbl_raddr (tbl_raddr),
		.tbl_rdata (tbl_rdata),
		.res_valid (res_valid),
		.res       (res)
	);

	rlc_table_ram #(
		.DEPTH (MAX_RUNS),
		.AW    (AW)
	) u_table (
		.clk   (clk),
		.wr    (tbl_wr),
		.waddr (tbl_waddr),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	rlc_out_buf u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.res_valid  (res_valid),
		.res        (res),
		.take_ready (item_ready),
		.out_valid  (result_valid),
		.out_ready  (result_ready),
		.out_res    (result)
	);

	`RLC_ASSERT(a_err_only_last, result_valid && (result.error != ERR_NONE), result.is_last,
		"error code on a result that is not last")
	`RLC_ASSERT(a_marker_last, result_valid && (result.kind == KIND_END), result.is_last,
		"end marker without is_last")
	`RLC_ASSERT(a_stall_full, !item_ready, result_valid,
		"input stalled while output stage is empty")
	`RLC_ASSERT_NEXT(a_skid_drains, result_valid && result_ready && !item_ready, item_ready,
		"skid stage did not drain after output transfer")

endmodule
